[hdl/sacpu_pkg.sv]
// Shared types and constants of the accumulator CPU execute block.
package sacpu_pkg;

    localparam int WORD_W       = 16;
    localparam int ADDR_FIELD_W = 12;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 120;

    // Bit positions of a few result fields inside the output beat.
    localparam int OUT_PC_LSB    = 48;
    localparam int OUT_HALT_BIT  = 114;
    localparam int OUT_FAULT_BIT = 115;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t BLANK_MAR = 16'd10;
    localparam logic [ADDR_FIELD_W-1:0] STACK_BASE_RESET = 12'd3840;

    typedef enum logic [3:0] {
        OP_BLANK, OP_LDA, OP_STA, OP_XAB, OP_CLA, OP_PUSH, OP_POP, OP_INC,
        OP_DEC, OP_MOV, OP_AND, OP_NOT, OP_OR, OP_XOR, OP_NOP, OP_HLT
    } func_t;

    typedef enum logic [2:0] {
        KIND_MEM, KIND_AX, KIND_BX, KIND_CX, KIND_PC, KIND_SP, KIND_BP, KIND_MAR
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_RD_LEFT, ST_RD_RIGHT, ST_EXEC
    } state_t;

endpackage

[hdl/sacpu_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module sacpu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/simple_accumulator_cpu_execute.sv]
// Execute stage of a 16-bit accumulator CPU with its data memory.
//
//  channel    dir  signals                       contents
//  s_axis     in   tvalid tready tdata[39:0]     one decoded instruction per beat
//  m_axis     out  tvalid tready tdata[119:0]    register file and flags after it
//  cfg        in   cfg_wr_en cfg_wr_data[11:0]   stack base, also loads SP and BP
//
// Every instruction goes through three states: left read, right read, execute and
// write back, all through the one read port and one write port of the RAM.
// A new instruction is taken in the execute cycle of the previous one.
// After reset the RAM is cleared one word a cycle, all 2**ADDR_BITS words, and
// no instruction is taken until that is done.
// A result waiting in the output register holds the execute cycle of the
// next instruction until it is taken.
module simple_accumulator_cpu_execute #(
    parameter int ADDR_BITS = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[3:0], left_kind[6:4], left_address[18:7], right_kind[21:19],
    // right_address[33:22], zeros above
    input  logic [39:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // reg_ax[15:0], reg_bx[31:16], reg_cx[47:32], reg_pc[63:48],
    // reg_sp[79:64], reg_bp[95:80], reg_mar[111:96], zero_flag[112],
    // negative_flag[113], halted[114], fault[115], zeros above
    output logic [119:0] m_axis_tdata,
    input  logic         cfg_wr_en,
    input  logic [11:0]  cfg_wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    typedef logic [ADDR_BITS-1:0] maddr_t;

    sacpu_pkg::state_t state_reg, state_next;

    sacpu_pkg::func_t  func_reg;
    sacpu_pkg::kind_t  lkind_reg, rkind_reg;
    logic [11:0]       laddr_reg, raddr_reg;
    sacpu_pkg::word_t  data0_reg;

    sacpu_pkg::word_t  ax_reg, bx_reg, cx_reg, pc_reg, sp_reg, bp_reg, mar_reg;
    logic              z_reg, n_reg, halt_reg, fault_reg;

    maddr_t            clr_addr_reg;
    logic              out_valid_reg;
    logic [119:0]      out_data_reg;

    logic              s_fire;
    logic              commit;
    logic              clr_last;

    logic              ram_we;
    maddr_t            ram_waddr;
    sacpu_pkg::word_t  ram_wdata;
    maddr_t            ram_raddr;
    sacpu_pkg::word_t  ram_rdata;

    logic [15:0]       laddr16, raddr16;
    maddr_t            left_maddr, right_maddr, sp_maddr, slot_maddr;
    sacpu_pkg::word_t  slot;

    sacpu_pkg::word_t  ax_nx, bx_nx, cx_nx, pc_nx, sp_nx, bp_nx, mar_nx;
    logic              z_nx, n_nx, halt_nx, fault_nx;
    logic              exec_we;
    maddr_t            exec_waddr;
    sacpu_pkg::word_t  exec_wdata;

    assign laddr16     = {4'b0000, laddr_reg};
    assign raddr16     = {4'b0000, raddr_reg};
    assign left_maddr  = laddr16[ADDR_BITS-1:0];
    assign right_maddr = raddr16[ADDR_BITS-1:0];
    assign sp_maddr    = sp_reg[ADDR_BITS-1:0];
    assign slot        = sp_reg - 16'd1;
    assign slot_maddr  = slot[ADDR_BITS-1:0];

    assign clr_last = (clr_addr_reg == {ADDR_BITS{1'b1}});
    assign s_fire   = s_axis_tvalid && s_axis_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sacpu_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = sacpu_pkg::ST_IDLE;
                end
            end
            sacpu_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = sacpu_pkg::ST_RD_LEFT;
                end
            end
            sacpu_pkg::ST_RD_LEFT:  state_next = sacpu_pkg::ST_RD_RIGHT;
            sacpu_pkg::ST_RD_RIGHT: state_next = sacpu_pkg::ST_EXEC;
            sacpu_pkg::ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = s_fire ? sacpu_pkg::ST_RD_LEFT : sacpu_pkg::ST_IDLE;
                end
            end
            default: state_next = sacpu_pkg::ST_IDLE;
        endcase
    end

    // State outputs: handshake and RAM port control
    always_comb
    begin
        commit        = 1'b0;
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = exec_waddr;
        ram_wdata     = exec_wdata;
        ram_raddr     = right_maddr;
        case (state_reg)
            sacpu_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            sacpu_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            sacpu_pkg::ST_RD_LEFT:
            begin
                ram_raddr = (func_reg == sacpu_pkg::OP_POP) ? slot_maddr : left_maddr;
            end
            sacpu_pkg::ST_RD_RIGHT:
            begin
                // POP empties its slot here; the popped word was read in the left-read state.
                if (func_reg == sacpu_pkg::OP_POP && !halt_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_maddr;
                    ram_wdata = '0;
                end
            end
            sacpu_pkg::ST_EXEC:
            begin
                commit        = !out_valid_reg || m_axis_tready;
                s_axis_tready = commit;
                ram_we        = commit && exec_we;
            end
            default:
            begin
                commit = 1'b0;
            end
        endcase
    end

    // Instruction execution
    always_comb
    begin
        sacpu_pkg::word_t pc_inc;
        sacpu_pkg::word_t mar_base;
        sacpu_pkg::word_t lv;
        sacpu_pkg::word_t rv;
        sacpu_pkg::word_t dec_val;
        sacpu_pkg::word_t res;
        logic             wr_left;

        pc_inc   = pc_reg + 16'd1;
        mar_base = (func_reg == sacpu_pkg::OP_BLANK) ? sacpu_pkg::BLANK_MAR : '0;

        case (lkind_reg)
            sacpu_pkg::KIND_AX:  lv = ax_reg;
            sacpu_pkg::KIND_BX:  lv = bx_reg;
            sacpu_pkg::KIND_CX:  lv = cx_reg;
            sacpu_pkg::KIND_PC:  lv = pc_inc;
            sacpu_pkg::KIND_SP:  lv = sp_reg;
            sacpu_pkg::KIND_BP:  lv = bp_reg;
            sacpu_pkg::KIND_MAR: lv = mar_base;
            default:             lv = data0_reg;
        endcase

        case (rkind_reg)
            sacpu_pkg::KIND_AX:  rv = ax_reg;
            sacpu_pkg::KIND_BX:  rv = bx_reg;
            sacpu_pkg::KIND_CX:  rv = cx_reg;
            sacpu_pkg::KIND_PC:  rv = pc_inc;
            sacpu_pkg::KIND_SP:  rv = sp_reg;
            sacpu_pkg::KIND_BP:  rv = bp_reg;
            sacpu_pkg::KIND_MAR: rv = mar_base;
            default:             rv = ram_rdata;
        endcase

        dec_val = lv - 16'd1;

        ax_nx      = ax_reg;
        bx_nx      = bx_reg;
        cx_nx      = cx_reg;
        pc_nx      = pc_reg;
        sp_nx      = sp_reg;
        bp_nx      = bp_reg;
        mar_nx     = mar_reg;
        z_nx       = z_reg;
        n_nx       = n_reg;
        halt_nx    = halt_reg;
        fault_nx   = fault_reg;
        exec_we    = 1'b0;
        exec_waddr = left_maddr;
        exec_wdata = '0;
        res        = '0;
        wr_left    = 1'b0;

        if (!halt_reg)
        begin
            pc_nx  = pc_inc;
            mar_nx = mar_base;

            case (func_reg)
                sacpu_pkg::OP_BLANK:
                begin
                    halt_nx  = 1'b1;
                    fault_nx = 1'b1;
                end
                sacpu_pkg::OP_LDA: ax_nx = lv;
                sacpu_pkg::OP_STA:
                begin
                    res     = ax_reg;
                    wr_left = 1'b1;
                end
                sacpu_pkg::OP_XAB:
                begin
                    ax_nx = bx_reg;
                    bx_nx = ax_reg;
                end
                sacpu_pkg::OP_CLA: ax_nx = '0;
                sacpu_pkg::OP_PUSH:
                begin
                    exec_we    = 1'b1;
                    exec_waddr = sp_maddr;
                    exec_wdata = lv;
                end
                sacpu_pkg::OP_POP:
                begin
                    res     = data0_reg;
                    wr_left = 1'b1;
                end
                sacpu_pkg::OP_INC:
                begin
                    res     = lv + 16'd1;
                    wr_left = 1'b1;
                end
                sacpu_pkg::OP_DEC:
                begin
                    res     = dec_val;
                    wr_left = 1'b1;
                    if (dec_val == '0)
                    begin
                        z_nx = 1'b1;
                    end
                    else if (lv == '0)
                    begin
                        // Underflow does not wrap: the operand becomes one.
                        res  = 16'd1;
                        n_nx = 1'b1;
                    end
                end
                sacpu_pkg::OP_MOV:
                begin
                    res     = rv;
                    wr_left = 1'b1;
                end
                sacpu_pkg::OP_AND:
                begin
                    res     = lv & rv;
                    wr_left = 1'b1;
                end
                sacpu_pkg::OP_NOT:
                begin
                    res     = ~lv;
                    wr_left = 1'b1;
                end
                sacpu_pkg::OP_OR:
                begin
                    res     = lv | rv;
                    wr_left = 1'b1;
                end
                sacpu_pkg::OP_XOR:
                begin
                    res     = lv ^ rv;
                    wr_left = 1'b1;
                end
                sacpu_pkg::OP_HLT:
                begin
                    halt_nx  = 1'b1;
                    fault_nx = 1'b0;
                end
                default:
                begin
                    wr_left = 1'b0;
                end
            endcase

            if (wr_left)
            begin
                case (lkind_reg)
                    sacpu_pkg::KIND_AX:  ax_nx  = res;
                    sacpu_pkg::KIND_BX:  bx_nx  = res;
                    sacpu_pkg::KIND_CX:  cx_nx  = res;
                    sacpu_pkg::KIND_PC:  pc_nx  = res;
                    sacpu_pkg::KIND_SP:  sp_nx  = res;
                    sacpu_pkg::KIND_BP:  bp_nx  = res;
                    sacpu_pkg::KIND_MAR: mar_nx = res;
                    default:
                    begin
                        exec_we    = 1'b1;
                        exec_waddr = left_maddr;
                        exec_wdata = res;
                    end
                endcase
            end

            // The stack pointer update comes last, so it wins over an SP operand.
            if (func_reg == sacpu_pkg::OP_PUSH)
            begin
                sp_nx = sp_reg + 16'd1;
            end
            else if (func_reg == sacpu_pkg::OP_POP)
            begin
                sp_nx = slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sacpu_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            ax_reg         <= '0;
            bx_reg         <= '0;
            cx_reg         <= '0;
            pc_reg         <= '0;
            sp_reg         <= {4'b0000, sacpu_pkg::STACK_BASE_RESET};
            bp_reg         <= {4'b0000, sacpu_pkg::STACK_BASE_RESET};
            mar_reg        <= '0;
            z_reg          <= 1'b0;
            n_reg          <= 1'b0;
            halt_reg       <= 1'b0;
            fault_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == sacpu_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + maddr_t'(1);
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                ax_reg    <= ax_nx;
                bx_reg    <= bx_nx;
                cx_reg    <= cx_nx;
                pc_reg    <= pc_nx;
                bp_reg    <= bp_nx;
                sp_reg    <= sp_nx;
                mar_reg   <= mar_nx;
                z_reg     <= z_nx;
                n_reg     <= n_nx;
                halt_reg  <= halt_nx;
                fault_reg <= fault_nx;
            end

            if (cfg_wr_en)
            begin
                sp_reg         <= {4'b0000, cfg_wr_data};
                bp_reg         <= {4'b0000, cfg_wr_data};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            func_reg  <= sacpu_pkg::func_t'(s_axis_tdata[3:0]);
            lkind_reg <= sacpu_pkg::kind_t'(s_axis_tdata[6:4]);
            laddr_reg <= s_axis_tdata[18:7];
            rkind_reg <= sacpu_pkg::kind_t'(s_axis_tdata[21:19]);
            raddr_reg <= s_axis_tdata[33:22];
        end
        if (state_reg == sacpu_pkg::ST_RD_RIGHT)
        begin
            data0_reg <= ram_rdata;
        end
        if (commit)
        begin
            out_data_reg <= {4'b0000, fault_nx, halt_nx, n_nx, z_nx, mar_nx, bp_nx,
                             sp_nx, pc_nx, cx_nx, bx_nx, ax_nx};
        end
    end

    sacpu_ram #(
        .WIDTH (sacpu_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[hdl/sacpu_checker.sv]
// Port-level checks on the result stream of the execute block, bound to its top level.
module sacpu_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [sacpu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic             seen_halt_reg;
    sacpu_pkg::word_t last_pc_reg;
    logic             out_halted;
    logic             out_fault;
    sacpu_pkg::word_t out_pc;

    assign out_halted = m_axis_tdata[sacpu_pkg::OUT_HALT_BIT];
    assign out_fault  = m_axis_tdata[sacpu_pkg::OUT_FAULT_BIT];
    assign out_pc     = m_axis_tdata[sacpu_pkg::OUT_PC_LSB +: sacpu_pkg::WORD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
            last_pc_reg   <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready && out_halted)
        begin
            seen_halt_reg <= 1'b1;
            last_pc_reg   <= out_pc;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!out_fault || out_halted))
        else $error("fault reported without halt");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && seen_halt_reg |-> out_halted)
        else $error("halt cleared without reset");

    a_pc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && seen_halt_reg |-> (out_pc == last_pc_reg))
        else $error("program counter moved after halt");

endmodule

bind simple_accumulator_cpu_execute sacpu_checker u_sacpu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/tb_top.sv]
// Self-checking testbench for the accumulator CPU execute stage.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_FIELD_W   = sacpu_pkg::ADDR_FIELD_W;
    localparam int WORD_W         = sacpu_pkg::WORD_W;
    localparam int MEM_WORDS      = 4096;
    localparam int PHASE_ITEMS    = 200;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 12000;

    // Bit layout matches the input beat: func in the lowest bits.
    typedef struct packed {
        logic [ADDR_FIELD_W-1:0] ra;
        sacpu_pkg::kind_t        rk;
        logic [ADDR_FIELD_W-1:0] la;
        sacpu_pkg::kind_t        lk;
        sacpu_pkg::func_t        func;
    } instr_t;

    // Bit layout matches the output beat: AX in the lowest bits.
    typedef struct packed {
        logic             fault;
        logic             halt;
        logic             n;
        logic             z;
        sacpu_pkg::word_t mar;
        sacpu_pkg::word_t bp;
        sacpu_pkg::word_t sp;
        sacpu_pkg::word_t pc;
        sacpu_pkg::word_t cx;
        sacpu_pkg::word_t bx;
        sacpu_pkg::word_t ax;
    } regs_t;

    typedef struct {
        instr_t ins;
        bit     typed;
        regs_t  want;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [11:0]  cfg_wr_data = '0;

    // Shadow copy of the CPU state, advanced once per accepted instruction.
    sacpu_pkg::word_t sh_mem [MEM_WORDS];
    sacpu_pkg::word_t sh_ax, sh_bx, sh_cx, sh_pc, sh_sp, sh_bp, sh_mar;
    logic             sh_z, sh_n, sh_halt, sh_fault;

    regs_t expected_regs [$];
    int    items_sent = 0;
    int    results_checked = 0;
    int    errors = 0;
    int    bases_used = 0;
    int    quiet_cycles = 0;
    int    hold_left = 0;
    int    stall_left = 0;
    bit    hold_req = 1'b0;
    bit    send_gaps = 1'b0;
    bit    recv_stalls = 1'b0;

    simple_accumulator_cpu_execute #(
        .ADDR_BITS(12)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic sacpu_pkg::word_t opnd_get(sacpu_pkg::kind_t k,
                                                  logic [ADDR_FIELD_W-1:0] a);
        case (k)
            sacpu_pkg::KIND_AX:  return sh_ax;
            sacpu_pkg::KIND_BX:  return sh_bx;
            sacpu_pkg::KIND_CX:  return sh_cx;
            sacpu_pkg::KIND_PC:  return sh_pc;
            sacpu_pkg::KIND_SP:  return sh_sp;
            sacpu_pkg::KIND_BP:  return sh_bp;
            sacpu_pkg::KIND_MAR: return sh_mar;
            default:             return sh_mem[a];
        endcase
    endfunction

    function automatic void opnd_put(sacpu_pkg::kind_t k, logic [ADDR_FIELD_W-1:0] a,
                                     sacpu_pkg::word_t v);
        case (k)
            sacpu_pkg::KIND_AX:  sh_ax = v;
            sacpu_pkg::KIND_BX:  sh_bx = v;
            sacpu_pkg::KIND_CX:  sh_cx = v;
            sacpu_pkg::KIND_PC:  sh_pc = v;
            sacpu_pkg::KIND_SP:  sh_sp = v;
            sacpu_pkg::KIND_BP:  sh_bp = v;
            sacpu_pkg::KIND_MAR: sh_mar = v;
            default:             sh_mem[a] = v;
        endcase
    endfunction

    // Executes one instruction on the shadow state and returns the register view.
    function automatic regs_t exec_instr(instr_t i);
        sacpu_pkg::word_t a;
        sacpu_pkg::word_t b;
        sacpu_pkg::word_t slot;
        regs_t r;
        if (!sh_halt)
        begin
            sh_pc = sh_pc + 16'd1;
            sh_mar = (i.func == sacpu_pkg::OP_BLANK) ? sacpu_pkg::BLANK_MAR : '0;
            case (i.func)
                sacpu_pkg::OP_BLANK:
                begin
                    sh_halt = 1'b1;
                    sh_fault = 1'b1;
                end
                sacpu_pkg::OP_LDA: sh_ax = opnd_get(i.lk, i.la);
                sacpu_pkg::OP_STA: opnd_put(i.lk, i.la, sh_ax);
                sacpu_pkg::OP_XAB:
                begin
                    a = sh_ax;
                    sh_ax = sh_bx;
                    sh_bx = a;
                end
                sacpu_pkg::OP_CLA: sh_ax = '0;
                sacpu_pkg::OP_PUSH:
                begin
                    a = opnd_get(i.lk, i.la);
                    sh_mem[sh_sp[ADDR_FIELD_W-1:0]] = a;
                    sh_sp = sh_sp + 16'd1;
                end
                sacpu_pkg::OP_POP:
                begin
                    // The slot is cleared and SP is written last, so it wins over an SP operand.
                    slot = sh_sp - 16'd1;
                    a = sh_mem[slot[ADDR_FIELD_W-1:0]];
                    sh_mem[slot[ADDR_FIELD_W-1:0]] = '0;
                    opnd_put(i.lk, i.la, a);
                    sh_sp = slot;
                end
                sacpu_pkg::OP_INC: opnd_put(i.lk, i.la, opnd_get(i.lk, i.la) + 16'd1);
                sacpu_pkg::OP_DEC:
                begin
                    a = opnd_get(i.lk, i.la) - 16'd1;
                    if (a == '0)
                        sh_z = 1'b1;
                    else if (a == 16'hFFFF)
                    begin
                        a = 16'd1;
                        sh_n = 1'b1;
                    end
                    opnd_put(i.lk, i.la, a);
                end
                sacpu_pkg::OP_MOV: opnd_put(i.lk, i.la, opnd_get(i.rk, i.ra));
                sacpu_pkg::OP_AND, sacpu_pkg::OP_OR, sacpu_pkg::OP_XOR:
                begin
                    a = opnd_get(i.lk, i.la);
                    b = opnd_get(i.rk, i.ra);
                    if (i.func == sacpu_pkg::OP_AND)
                        a = a & b;
                    else if (i.func == sacpu_pkg::OP_OR)
                        a = a | b;
                    else
                        a = a ^ b;
                    opnd_put(i.lk, i.la, a);
                end
                sacpu_pkg::OP_NOT: opnd_put(i.lk, i.la, ~opnd_get(i.lk, i.la));
                sacpu_pkg::OP_HLT:
                begin
                    sh_halt = 1'b1;
                    sh_fault = 1'b0;
                end
                default: ;
            endcase
        end
        r.ax = sh_ax;
        r.bx = sh_bx;
        r.cx = sh_cx;
        r.pc = sh_pc;
        r.sp = sh_sp;
        r.bp = sh_bp;
        r.mar = sh_mar;
        r.z = sh_z;
        r.n = sh_n;
        r.halt = sh_halt;
        r.fault = sh_fault;
        return r;
    endfunction

    function automatic instr_t instr(sacpu_pkg::func_t f, sacpu_pkg::kind_t lk, int la,
                                     sacpu_pkg::kind_t rk, int ra);
        instr_t i;
        i.func = f;
        i.lk = lk;
        i.la = ADDR_FIELD_W'(la);
        i.rk = rk;
        i.ra = ADDR_FIELD_W'(ra);
        return i;
    endfunction

    // Register view of a running CPU: MAR is 0 and nothing has halted.
    function automatic regs_t regs(int ax, int bx, int cx, int pc, int sp, int bp,
                                   logic z, logic n);
        regs_t r;
        r = '0;
        r.ax = WORD_W'(ax);
        r.bx = WORD_W'(bx);
        r.cx = WORD_W'(cx);
        r.pc = WORD_W'(pc);
        r.sp = WORD_W'(sp);
        r.bp = WORD_W'(bp);
        r.z = z;
        r.n = n;
        return r;
    endfunction

    function automatic sacpu_pkg::kind_t pick_kind();
        if ($urandom_range(0, 2) == 0)
            return sacpu_pkg::KIND_MEM;
        return sacpu_pkg::kind_t'($urandom_range(0, 7));
    endfunction

    // Mostly a few hot words and the area around the stack, so reads see written data.
    function automatic logic [ADDR_FIELD_W-1:0] pick_addr();
        case ($urandom_range(0, 4))
            0, 1:    return ADDR_FIELD_W'($urandom_range(0, 15));
            2:       return sh_sp[ADDR_FIELD_W-1:0] + ADDR_FIELD_W'($urandom_range(0, 7))
                            - ADDR_FIELD_W'(4);
            default: return ADDR_FIELD_W'($urandom);
        endcase
    endfunction

    function automatic instr_t rand_instr(bit any_func);
        instr_t i;
        if (any_func)
            i.func = sacpu_pkg::func_t'($urandom_range(0, 15));
        else if ($urandom_range(0, 4) == 0)
            i.func = $urandom_range(0, 1) ? sacpu_pkg::OP_PUSH : sacpu_pkg::OP_POP;
        else
            i.func = sacpu_pkg::func_t'($urandom_range(1, 14));
        i.lk = pick_kind();
        i.la = pick_addr();
        i.rk = pick_kind();
        i.ra = pick_addr();
        return i;
    endfunction

    function automatic void cmp(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic check_regs(regs_t got);
        regs_t want;
        if (expected_regs.size() == 0)
        begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = expected_regs.pop_front();
        cmp("reg_ax", want.ax, got.ax);
        cmp("reg_bx", want.bx, got.bx);
        cmp("reg_cx", want.cx, got.cx);
        cmp("reg_pc", want.pc, got.pc);
        cmp("reg_sp", want.sp, got.sp);
        cmp("reg_bp", want.bp, got.bp);
        cmp("reg_mar", want.mar, got.mar);
        cmp("zero_flag", 16'(want.z), 16'(got.z));
        cmp("negative_flag", 16'(want.n), 16'(got.n));
        cmp("halted", 16'(want.halt), 16'(got.halt));
        cmp("fault", 16'(want.fault), 16'(got.fault));
        results_checked++;
    endtask

    // Offers one instruction and records what it should produce once accepted.
    task automatic issue(instr_t ins, bit typed, regs_t want);
        regs_t pred;
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, ins};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = exec_instr(ins);
        expected_regs.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_regs.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_stack_base(logic [11:0] v);
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sh_sp = {4'b0, v};
        sh_bp = {4'b0, v};
        bases_used++;
    endtask

    // Result side: random stalls, plus one long hold-off that backs the pipeline up.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                check_regs(regs_t'(m_axis_tdata[115:0]));
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_stalls && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
                     quiet_cycles, expected_regs.size());
            $display("simple_accumulator_cpu_execute test failed");
            $finish;
        end
    end

    initial
    begin
        row_t             dir_q [$];
        logic [11:0]      bases [4];
        sacpu_pkg::func_t term;

        foreach (sh_mem[k])
            sh_mem[k] = '0;
        sh_ax = '0;
        sh_bx = '0;
        sh_cx = '0;
        sh_pc = '0;
        sh_mar = '0;
        sh_sp = {4'b0, sacpu_pkg::STACK_BASE_RESET};
        sh_bp = {4'b0, sacpu_pkg::STACK_BASE_RESET};
        sh_z = 1'b0;
        sh_n = 1'b0;
        sh_halt = 1'b0;
        sh_fault = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Decrement from zero underflows to 1, PC reads see the advanced value,
        // and popping into SP leaves SP at the slot.
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_NOP, sacpu_pkg::KIND_MEM, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs(0, 0, 0, 1, 3840, 3840, 0, 0)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_DEC, sacpu_pkg::KIND_AX, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs(1, 0, 0, 2, 3840, 3840, 0, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_DEC, sacpu_pkg::KIND_AX, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs(0, 0, 0, 3, 3840, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_NOT, sacpu_pkg::KIND_AX, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs('hFFFF, 0, 0, 4, 3840, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_INC, sacpu_pkg::KIND_AX, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs(0, 0, 0, 5, 3840, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_NOT, sacpu_pkg::KIND_CX, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs(0, 0, 'hFFFF, 6, 3840, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_MOV, sacpu_pkg::KIND_MEM, 4095,
                                     sacpu_pkg::KIND_CX, 0),
                               1'b1, regs(0, 0, 'hFFFF, 7, 3840, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_LDA, sacpu_pkg::KIND_MEM, 4095,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs('hFFFF, 0, 'hFFFF, 8, 3840, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_XAB, sacpu_pkg::KIND_MEM, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs(0, 'hFFFF, 'hFFFF, 9, 3840, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_PUSH, sacpu_pkg::KIND_BX, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs(0, 'hFFFF, 'hFFFF, 10, 3841, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_PUSH, sacpu_pkg::KIND_PC, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs(0, 'hFFFF, 'hFFFF, 11, 3842, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_POP, sacpu_pkg::KIND_AX, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs(11, 'hFFFF, 'hFFFF, 12, 3841, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_POP, sacpu_pkg::KIND_SP, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs(11, 'hFFFF, 'hFFFF, 13, 3840, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_POP, sacpu_pkg::KIND_MEM, 0,
                                     sacpu_pkg::KIND_MEM, 0),
                               1'b1, regs(11, 'hFFFF, 'hFFFF, 14, 3839, 3840, 1, 1)});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_MOV, sacpu_pkg::KIND_CX, 0,
                                     sacpu_pkg::KIND_PC, 0), 1'b0, '0});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_OR, sacpu_pkg::KIND_MAR, 0,
                                     sacpu_pkg::KIND_BX, 0), 1'b0, '0});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_XOR, sacpu_pkg::KIND_BX, 0,
                                     sacpu_pkg::KIND_MEM, 4095), 1'b0, '0});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_AND, sacpu_pkg::KIND_AX, 0,
                                     sacpu_pkg::KIND_CX, 0), 1'b0, '0});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_MOV, sacpu_pkg::KIND_BP, 0,
                                     sacpu_pkg::KIND_AX, 0), 1'b0, '0});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_INC, sacpu_pkg::KIND_SP, 0,
                                     sacpu_pkg::KIND_MEM, 0), 1'b0, '0});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_DEC, sacpu_pkg::KIND_PC, 0,
                                     sacpu_pkg::KIND_MEM, 0), 1'b0, '0});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_STA, sacpu_pkg::KIND_MEM, 2048,
                                     sacpu_pkg::KIND_MEM, 0), 1'b0, '0});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_CLA, sacpu_pkg::KIND_MEM, 0,
                                     sacpu_pkg::KIND_MEM, 0), 1'b0, '0});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_LDA, sacpu_pkg::KIND_MEM, 2048,
                                     sacpu_pkg::KIND_MEM, 0), 1'b0, '0});
        dir_q.push_back(row_t'{instr(sacpu_pkg::OP_MOV, sacpu_pkg::KIND_MEM, 1365,
                                     sacpu_pkg::KIND_MEM, 2730), 1'b0, '0});
        foreach (dir_q[k])
            issue(dir_q[k].ins, dir_q[k].typed, dir_q[k].want);
        drain();

        // Stack base extremes first, so the stack address wraps at both ends.
        bases[0] = 12'd0;
        bases[1] = 12'd4095;
        bases[2] = 12'($urandom);
        bases[3] = sacpu_pkg::STACK_BASE_RESET;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_stack_base(bases[ph]);
            send_gaps = (ph != 2);
            recv_stalls = (ph < 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 1 && k == 40)
                    hold_req = 1'b1;
                issue(rand_instr(1'b0), 1'b0, '0);
            end
            drain();
        end

        // Only reset clears a halt, so termination comes last; the state must then
        // stay frozen apart from a stack base write.
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        repeat (40) issue(rand_instr(1'b0), 1'b0, '0);
        term = $urandom_range(0, 1) ? sacpu_pkg::OP_HLT : sacpu_pkg::OP_BLANK;
        issue(instr(term, pick_kind(), 0, pick_kind(), 0), 1'b0, '0);
        repeat (8) issue(rand_instr(1'b1), 1'b0, '0);
        drain();
        set_stack_base(12'($urandom));
        repeat (4) issue(rand_instr(1'b1), 1'b0, '0);
        drain();
        repeat (10) @(posedge clk);

        $display("Covered %0d instructions under %0d stack base writes, %0d results checked.",
                 items_sent, bases_used, results_checked);
        $display("The run stopped on %s and was then held halted; %0d mismatches.",
                 term.name(), errors);
        if (errors == 0)
            $display("simple_accumulator_cpu_execute test passed");
        else
            $display("simple_accumulator_cpu_execute test failed");
        $finish;
    end

endmodule
